// ----- rtl/ffrc_pkg.sv -----
package ffrc_pkg;

	localparam int BYTE_W          = 8;
	localparam int LEN_W           = 6;
	localparam int CFG_W           = 8;
	localparam int CFG_IDX_W       = 3;
	localparam int MAX_PAYLOAD_DEF = 32;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TAIL_FIRST      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TAIL_SECOND     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH_FIELD_ON = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LEN     = 3'd5;

	localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'hA5;
	localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'h00;
	localparam logic [BYTE_W-1:0] TAIL_FIRST_RST    = 8'h5A;
	localparam logic [BYTE_W-1:0] TAIL_SECOND_RST   = 8'h00;
	localparam logic [LEN_W-1:0]  PAYLOAD_LEN_RST   = 6'd16;

	typedef enum logic [1:0] {
		ST_RECV,
		ST_DRAIN_RD,
		ST_DRAIN_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic step;        // take one received byte
		logic drain_rd;    // read the next payload entry
		logic drain_next;  // advance the read pointer
	} dp_cmd_t;

	typedef struct packed {
		logic frame_good;  // this step closed a verified frame
		logic at_last;     // entry on the output is the final one
	} dp_status_t;

endpackage

// ----- rtl/ffrc_ram.sv -----
module ffrc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/ffrc_datapath.sv -----
module ffrc_datapath import ffrc_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic [BYTE_W-1:0]    rx_byte,
	input  dp_cmd_t              cmd,
	output dp_status_t           status,
	output logic [BYTE_W-1:0]    payload_byte,
	output logic                 last
);

	localparam int POS_W = $clog2(MAX_PAYLOAD + 7);
	localparam int PW    = $clog2(MAX_PAYLOAD + 1);
	localparam int PEW   = LEN_W + 1;
	localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	// config registers
	logic [BYTE_W-1:0] hf_q, hs_q, tf_q, ts_q;
	logic              lf_q;
	logic [LEN_W-1:0]  plen_q;

	// frame state
	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] sum_q, ck_q;
	logic              lenok_q, ftm_q;

	// burst state
	logic [PW-1:0]     rd_q, cnt_q;
	logic              last_q;

	// geometry from the current registers
	logic [PEW-1:0]    p_ext;
	logic [PW-1:0]     p_eff;
	logic [POS_W-1:0]  hdr, tl, lf, pay_start, ck_pos, frame_len, pos_inc, slot;
	logic              two_hdr;

	// next values
	logic [POS_W-1:0]  pos_n;
	logic [BYTE_W-1:0] sum_n, ck_n;
	logic              lenok_n, ftm_n;
	logic              main_path, done, tail_ok, good, restart, ram_we;

	always_comb begin
		if (plen_q == '0) begin
			p_ext = PEW'(1);
		end else if ({1'b0, plen_q} > PEW'(MAX_PAYLOAD)) begin
			p_ext = PEW'(MAX_PAYLOAD);
		end else begin
			p_ext = {1'b0, plen_q};
		end
		p_eff     = PW'(p_ext);
		two_hdr   = (hs_q != '0);
		hdr       = two_hdr ? POS_W'(2) : POS_W'(1);
		tl        = (ts_q != '0) ? POS_W'(2) : POS_W'(1);
		lf        = POS_W'(lf_q);
		pay_start = hdr + lf;
		ck_pos    = pay_start + POS_W'(p_eff);
		frame_len = ck_pos + POS_W'(1) + tl;
		pos_inc   = pos_q + POS_W'(1);
		slot      = pos_q - pay_start;
	end

	always_comb begin
		pos_n     = pos_q;
		sum_n     = sum_q;
		ck_n      = ck_q;
		lenok_n   = lenok_q;
		ftm_n     = ftm_q;
		main_path = 1'b0;
		ram_we    = 1'b0;
		restart   = 1'b0;
		done      = 1'b0;
		if (pos_q == '0) begin
			if (rx_byte == hf_q) begin
				restart = 1'b1;
				pos_n   = POS_W'(1);
			end
		end else if (two_hdr && pos_q == POS_W'(1)) begin
			if (rx_byte == hs_q) begin
				pos_n = POS_W'(2);
			end else if (rx_byte != hf_q) begin
				restart = 1'b1;
				pos_n   = '0;
			end
		end else begin
			main_path = 1'b1;
			if (lf_q && pos_q == hdr) begin
				lenok_n = (rx_byte == {1'b0, p_ext});
				sum_n   = sum_q + rx_byte;
			end else if (pos_q >= pay_start && pos_q < ck_pos) begin
				ram_we = 1'b1;
				sum_n  = sum_q + rx_byte;
			end else if (pos_q == ck_pos) begin
				ck_n = rx_byte;
			end else if (pos_q == ck_pos + POS_W'(1)) begin
				ftm_n = (rx_byte == tf_q);
			end
			if (pos_inc < frame_len) begin
				pos_n = pos_inc;
			end else begin
				done    = 1'b1;
				restart = 1'b1;
				pos_n   = '0;
			end
		end
		tail_ok = (ts_q != '0) ? (ftm_n && rx_byte == ts_q) : ftm_n;
		good    = main_path && done && tail_ok && lenok_n && (sum_n == ck_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hf_q   <= HEADER_FIRST_RST;
			hs_q   <= HEADER_SECOND_RST;
			tf_q   <= TAIL_FIRST_RST;
			ts_q   <= TAIL_SECOND_RST;
			lf_q   <= 1'b0;
			plen_q <= PAYLOAD_LEN_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_HEADER_FIRST:    hf_q   <= cfg_wdata;
				REG_HEADER_SECOND:   hs_q   <= cfg_wdata;
				REG_TAIL_FIRST:      tf_q   <= cfg_wdata;
				REG_TAIL_SECOND:     ts_q   <= cfg_wdata;
				REG_LENGTH_FIELD_ON: lf_q   <= cfg_wdata[0];
				REG_PAYLOAD_LEN:     plen_q <= cfg_wdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			sum_q   <= '0;
			ck_q    <= '0;
			lenok_q <= 1'b1;
			ftm_q   <= 1'b0;
		end else if (cmd.step) begin
			pos_q <= pos_n;
			if (restart) begin
				sum_q   <= '0;
				ck_q    <= '0;
				lenok_q <= 1'b1;
				ftm_q   <= 1'b0;
			end else begin
				sum_q   <= sum_n;
				ck_q    <= ck_n;
				lenok_q <= lenok_n;
				ftm_q   <= ftm_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q   <= '0;
			cnt_q  <= '0;
			last_q <= 1'b0;
		end else begin
			if (cmd.step && good) begin
				rd_q  <= '0;
				cnt_q <= p_eff;
			end else if (cmd.drain_next) begin
				rd_q <= rd_q + PW'(1);
			end
			if (cmd.drain_rd) begin
				last_q <= (rd_q == cnt_q - PW'(1));
			end
		end
	end

	ffrc_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(MAX_PAYLOAD)
	) u_store (
		.clk  (clk),
		.we   (cmd.step && ram_we),
		.waddr(AW'(slot)),
		.wdata(rx_byte),
		.re   (cmd.drain_rd),
		.raddr(rd_q[AW-1:0]),
		.rdata(payload_byte)
	);

	assign status.frame_good = cmd.step && good;
	assign status.at_last    = last_q;
	assign last              = last_q;

endmodule

// ----- rtl/ffrc_ctrl.sv -----
module ffrc_ctrl import ffrc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	ctrl_state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RECV;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n        = state_q;
		cmd.step       = 1'b0;
		cmd.drain_rd   = 1'b0;
		cmd.drain_next = 1'b0;
		in_stall       = 1'b1;
		out_valid      = 1'b0;
		case (state_q)
			ST_RECV: begin
				in_stall = 1'b0;
				cmd.step = in_valid;
				if (status.frame_good) begin
					state_n = ST_DRAIN_RD;
				end
			end
			ST_DRAIN_RD: begin
				cmd.drain_rd = 1'b1;
				state_n      = ST_DRAIN_OUT;
			end
			ST_DRAIN_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					if (status.at_last) begin
						state_n = ST_RECV;
					end else begin
						cmd.drain_next = 1'b1;
						state_n        = ST_DRAIN_RD;
					end
				end
			end
			default: begin
				state_n = ST_RECV;
			end
		endcase
	end

endmodule

// ----- rtl/fixed_frame_receiver_checksum.sv -----
// Fixed-length frame receiver with 8-bit additive checksum.
// Each received byte is taken while no payload burst is pending.
// A verified frame's payload leaves one byte at a time, each read from the
// store and then offered on the output, where out_stall can hold it; input
// is stalled until the last payload byte is taken.
// Async active-low reset: registers to defaults, hunting for a header.
module fixed_frame_receiver_checksum import ffrc_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [BYTE_W-1:0]    rx_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [BYTE_W-1:0]    payload_byte,
	output logic                 last
);

	dp_cmd_t    cmd;
	dp_status_t status;

	ffrc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.cmd      (cmd)
	);

	ffrc_datapath #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.rx_byte     (rx_byte),
		.cmd         (cmd),
		.status      (status),
		.payload_byte(payload_byte),
		.last        (last)
	);

endmodule

// ----- rtl/ffrc_checker.sv -----
module ffrc_checker import ffrc_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [BYTE_W-1:0] payload_byte,
	input logic              last
);

	// a stalled item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(payload_byte) && $stable(last))
		else $error("output item changed while stalled");

	// no byte is taken while a payload burst is pending
	a_in_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open during payload burst");

	// each payload byte needs a fresh store read
	a_out_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid)
		else $error("payload bytes issued back to back");

	// a taken byte is never followed directly by output
	a_in_then_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !out_valid)
		else $error("output right after an input item");

endmodule

bind fixed_frame_receiver_checksum ffrc_checker u_ffrc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.payload_byte(payload_byte),
	.last        (last)
);

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;
	import ffrc_pkg::*;

	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 80;
	localparam int RANDOM_ITEMS  = 370;

	typedef logic [BYTE_W-1:0] octet_t;

	typedef struct packed {
		octet_t data;
		logic   last;
	} payload_entry_t;

	typedef enum int {
		CLEAN,
		REPEAT_HDR,
		BAD_SUM,
		BAD_TAIL1,
		BAD_TAIL2,
		BAD_LENGTH,
		BROKEN_HDR2,
		CUT_SHORT
	} flaw_t;

	// Mirrors the deframer: register copies, frame progress, and the payload
	// bytes still owed by the block.
	class frame_tracker;
		octet_t           hdr_a   = HEADER_FIRST_RST;
		octet_t           hdr_b   = HEADER_SECOND_RST;
		octet_t           tail_a  = TAIL_FIRST_RST;
		octet_t           tail_b  = TAIL_SECOND_RST;
		bit               len_on  = 1'b0;
		logic [LEN_W-1:0] len_reg = PAYLOAD_LEN_RST;

		int unsigned offset      = 0;
		octet_t      held[MAX_PAYLOAD_DEF];
		bit          filled[MAX_PAYLOAD_DEF];
		octet_t      acc         = '0;
		octet_t      sent_sum    = '0;
		bit          len_good    = 1'b1;
		bit          tail_a_good = 1'b0;

		payload_entry_t pending_payload[$];
		int errors      = 0;
		int checked     = 0;
		int frames_good = 0;
		int frames_bad  = 0;

		function int unsigned eff_len();
			if (len_reg == '0) return 1;
			if (32'(len_reg) > MAX_PAYLOAD_DEF) return MAX_PAYLOAD_DEF;
			return 32'(len_reg);
		endfunction

		function bit all_written();
			foreach (filled[i]) begin
				if (!filled[i]) return 1'b0;
			end
			return 1'b1;
		endfunction

		function void hunt();
			offset      = 0;
			acc         = '0;
			sent_sum    = '0;
			len_good    = 1'b1;
			tail_a_good = 1'b0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_HEADER_FIRST:    hdr_a   = val;
				REG_HEADER_SECOND:   hdr_b   = val;
				REG_TAIL_FIRST:      tail_a  = val;
				REG_TAIL_SECOND:     tail_b  = val;
				REG_LENGTH_FIELD_ON: len_on  = val[0];
				REG_PAYLOAD_LEN:     len_reg = val[LEN_W-1:0];
				default: ;
			endcase
		endfunction

		function void take_rx_byte(octet_t b);
			int unsigned hdr_n, tail_n, p, first_pay, sum_at, total, at, k;
			bit tail_good;
			hdr_n     = (hdr_b != 0) ? 2 : 1;
			tail_n    = (tail_b != 0) ? 2 : 1;
			p         = eff_len();
			first_pay = hdr_n + len_on;
			sum_at    = first_pay + p;
			total     = sum_at + 1 + tail_n;
			at        = offset;
			if (at == 0) begin
				if (b == hdr_a) begin
					hunt();
					offset = 1;
				end
				return;
			end
			// waiting for the second header byte; a repeated first one holds here
			if (hdr_n == 2 && at == 1) begin
				if (b == hdr_b) begin
					offset = 2;
				end else if (b != hdr_a) begin
					hunt();
				end
				return;
			end
			if (len_on && at == hdr_n) begin
				len_good = (32'(b) == p);
				acc += b;
			end else if (at >= first_pay && at < sum_at) begin
				k = at - first_pay;
				if (k < MAX_PAYLOAD_DEF) begin
					held[k]   = b;
					filled[k] = 1'b1;
				end
				acc += b;
			end else if (at == sum_at) begin
				sent_sum = b;
			end else if (at == sum_at + 1) begin
				tail_a_good = (b == tail_a);
			end
			at++;
			// geometry follows the live registers, so the frame may end early
			if (at < total) begin
				offset = at;
				return;
			end
			tail_good = tail_a_good && (tail_n == 1 || b == tail_b);
			if (tail_good && len_good && acc == sent_sum) begin
				for (k = 0; k < p; k++) begin
					pending_payload.push_back('{data: held[k], last: (k + 1 == p)});
				end
				frames_good++;
			end else begin
				frames_bad++;
			end
			hunt();
		endfunction

		function void check_payload(octet_t d, logic l);
			payload_entry_t e;
			if (pending_payload.size() == 0) begin
				errors++;
				$error("unexpected payload_byte %02h (last %0b)", d, l);
				return;
			end
			e = pending_payload.pop_front();
			checked++;
			if (d !== e.data) begin
				errors++;
				$error("payload_byte: expected %02h, actual %02h", e.data, d);
			end
			if (l !== e.last) begin
				errors++;
				$error("last: expected %0b, actual %0b", e.last, l);
			end
		endfunction
	endclass

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	octet_t               rx_byte   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	octet_t               payload_byte;
	logic                 last;

	frame_tracker tracker = new;
	octet_t       frame_q[$];
	bit           hold_req   = 1'b0;
	bit           no_gaps    = 1'b0;
	int           rand_items = 0;
	int           bytes_sent = 0;
	int           settings   = 0;
	int           holds_done = 0;

	fixed_frame_receiver_checksum #(
		.MAX_PAYLOAD(MAX_PAYLOAD_DEF)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.payload_byte(payload_byte),
		.last        (last)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) tracker.check_payload(payload_byte, last);
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [LEN_W-1:0] pick_len();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7) return LEN_W'($urandom_range(1, 8));
		if (r < 9) return LEN_W'($urandom_range(9, 31));
		case ($urandom_range(0, 3))
			0: return 6'd0;
			1: return 6'd32;
			2: return 6'd33;
			default: return 6'd63;
		endcase
	endfunction

	function automatic flaw_t pick_flaw();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return CLEAN;
		if (r < 55) return REPEAT_HDR;
		if (r < 63) return BAD_SUM;
		if (r < 70) return BAD_TAIL1;
		if (r < 76) return BAD_TAIL2;
		if (r < 82) return BAD_LENGTH;
		if (r < 88) return BROKEN_HDR2;
		return CUT_SHORT;
	endfunction

	function automatic octet_t payload_value();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return octet_t'($urandom);
		endcase
	endfunction

	function automatic octet_t flip_some();
		return octet_t'($urandom_range(1, 255));
	endfunction

	// one frame for the current registers, with the requested defect
	function automatic void build_frame(flaw_t flaw);
		octet_t      sum, v;
		int unsigned p;
		frame_q.delete();
		p   = tracker.eff_len();
		sum = '0;
		frame_q.push_back(tracker.hdr_a);
		if (tracker.hdr_b != 0) begin
			if (flaw == REPEAT_HDR) frame_q.push_back(tracker.hdr_a);
			if (flaw == BROKEN_HDR2) begin
				do v = octet_t'($urandom); while (v == tracker.hdr_a || v == tracker.hdr_b);
				frame_q.push_back(v);
			end
			frame_q.push_back(tracker.hdr_b);
		end
		if (tracker.len_on) begin
			v = octet_t'(p);
			if (flaw == BAD_LENGTH) v ^= octet_t'(1 << $urandom_range(0, 7));
			frame_q.push_back(v);
			sum += v;
		end
		repeat (p) begin
			v = payload_value();
			frame_q.push_back(v);
			sum += v;
		end
		if (flaw == BAD_SUM) sum ^= flip_some();
		frame_q.push_back(sum);
		v = tracker.tail_a;
		if (flaw == BAD_TAIL1) v ^= flip_some();
		frame_q.push_back(v);
		if (tracker.tail_b != 0) begin
			v = tracker.tail_b;
			if (flaw == BAD_TAIL2) v ^= flip_some();
			frame_q.push_back(v);
		end
		if (flaw == CUT_SHORT) begin
			repeat ($urandom_range(1, frame_q.size() - 1)) void'(frame_q.pop_back());
		end
	endfunction

	task automatic send_byte(input octet_t b);
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (in_stall);
		tracker.take_rx_byte(b);
		bytes_sent++;
	endtask

	task automatic send_frame();
		int n;
		foreach (frame_q[i]) begin
			send_byte(frame_q[i]);
			n = no_gaps ? 0 : pick_gap();
			if (n > 0) begin
				in_valid <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		tracker.set_reg(idx, val);
	endtask

	task automatic apply_config(input octet_t hf, input octet_t hs, input octet_t tf,
	                            input octet_t ts, input logic lf, input logic [LEN_W-1:0] pl);
		write_reg(REG_HEADER_FIRST, hf);
		write_reg(REG_HEADER_SECOND, hs);
		write_reg(REG_TAIL_FIRST, tf);
		write_reg(REG_TAIL_SECOND, ts);
		write_reg(REG_LENGTH_FIELD_ON, CFG_W'(lf));
		write_reg(REG_PAYLOAD_LEN, CFG_W'(pl));
		cfg_wr_en <= 1'b0;
		settings++;
	endtask

	// Bring the block to rest before a register write. While some store entry
	// was never written, a half-received frame is closed out first.
	task automatic quiesce();
		octet_t f;
		while (tracker.offset != 0 && !tracker.all_written()) begin
			do f = octet_t'($urandom); while (f == tracker.hdr_a || f == tracker.hdr_b);
			send_byte(f);
		end
		in_valid <= 1'b0;
		while (tracker.pending_payload.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input int phase);
		int     frames;
		octet_t n;
		quiesce();
		case (phase)
			1: apply_config(8'h00, 8'hFF, 8'hFF, 8'h00, 1'b1, 6'd63);
			2: apply_config(8'hFF, 8'h00, 8'h00, 8'h01, 1'b0, 6'd32);
			3: apply_config(8'h3C, 8'h00, 8'hC3, 8'h00, 1'b1, 6'd33);
			default: apply_config(octet_t'($urandom),
				$urandom_range(0, 1) ? 8'h00 : flip_some(),
				octet_t'($urandom),
				$urandom_range(0, 1) ? 8'h00 : flip_some(),
				1'($urandom_range(0, 1)), pick_len());
		endcase
		// phase 2: back-to-back long frames against a receiver that holds off
		no_gaps = (phase == 2) || ($urandom_range(0, 5) == 0);
		if (phase == 2) hold_req = 1'b1;
		frames = (phase == 2) ? 3 : $urandom_range(2, 6);
		repeat (frames) begin
			if (rand_items >= RANDOM_ITEMS) break;
			if (!no_gaps && $urandom_range(0, 4) == 0) begin
				frame_q.delete();
				repeat ($urandom_range(1, 4)) begin
					do n = octet_t'($urandom); while (n == tracker.hdr_a);
					frame_q.push_back(n);
				end
				send_frame();
			end
			build_frame((phase == 2) ? CLEAN : pick_flaw());
			rand_items += frame_q.size();
			send_frame();
		end
		no_gaps = 1'b0;
	endtask

	initial begin : receiver
		int n;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				n = pick_gap();
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
					out_stall <= 1'b0;
				end
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
				repeat (n) begin
					@(posedge clk);
					if (hold_req) break;
				end
			end
		end
	end

	initial begin : stimulus
		int phase;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// length register 0 acts as 1; all-zero and all-one payload bytes
		apply_config(8'hFF, 8'h00, 8'h00, 8'h00, 1'b0, 6'd0);
		frame_q = {8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00};
		send_frame();
		quiesce();
		// two-byte header and tail with length byte: repeated first header and a
		// sum that wraps, then a wrong length byte, then a broken second header
		apply_config(8'h80, 8'h01, 8'h7F, 8'hFF, 1'b1, 6'd1);
		frame_q = {8'h80, 8'h80, 8'h01, 8'h01, 8'hFF, 8'h00, 8'h7F, 8'hFF,
		           8'h80, 8'h01, 8'h02, 8'h10, 8'h12, 8'h7F, 8'hFF, 8'h80, 8'h33};
		send_frame();

		phase = 0;
		while (rand_items < RANDOM_ITEMS) begin
			phase++;
			run_phase(phase);
		end

		in_valid <= 1'b0;
		while (tracker.pending_payload.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d bytes under %0d register settings; %0d frames passed, %0d rejected.",
		         bytes_sent, settings, tracker.frames_good, tracker.frames_bad);
		$display("Compared %0d payload bytes; receiver hold-offs: %0d.",
		         tracker.checked, holds_done);
		if (tracker.errors == 0 && tracker.pending_payload.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/ffrc_pkg.sv
rtl/ffrc_ram.sv
rtl/ffrc_datapath.sv
rtl/ffrc_ctrl.sv
rtl/fixed_frame_receiver_checksum.sv
rtl/ffrc_checker.sv
verif/tb_top.sv
